// ----- hw/rtl/p1_telegram_parser_assert.svh -----
// Assertion macros used by the telegram parser top level.
`ifndef P1_TELEGRAM_PARSER_ASSERT_SVH
`define P1_TELEGRAM_PARSER_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define P1TP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define P1TP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/p1tp_pkg.sv -----
// Types, codes and helper functions of the P1 telegram parser.
`timescale 1ns / 1ps

package p1tp_pkg;

    localparam logic [7:0]  CH_SLASH = 8'h2F;
    localparam logic [7:0]  CH_BANG  = 8'h21;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_EMPTY  = 3'd2,
        PH_LINES  = 3'd3,
        PH_CRC    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        K_HDR_CHAR = 3'd0,
        K_HDR_END  = 3'd1,
        K_LN_CHAR  = 3'd2,
        K_LN_END   = 3'd3,
        K_OK       = 3'd4,
        K_CRC_ERR  = 3'd5,
        K_ABANDON  = 3'd6
    } kind_t;

    // One parse event as it travels from the front end to the output stage.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] crc_calc;
        logic [15:0] crc_text;
    } event_t;

    // CRC-16/ARC, reflected, one byte.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // {valid, nibble} for an ASCII hex digit of either case.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h00;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/p1tp_front.sv -----
// Front end: parse state machine and running CRC, one byte per cycle while the event queue is not full.
`timescale 1ns / 1ps

module p1tp_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    input  logic             q_full,
    output logic             q_push,
    output p1tp_pkg::event_t q_data
);
    import p1tp_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [15:0] crc_reg,    crc_next;
    logic [15:0] text_reg,   text_next;
    logic        excess_reg, excess_next;
    logic        line_reg,   line_next;

    logic        accept;
    logic [7:0]  b;
    logic [4:0]  hex;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_in_byte;
    assign hex     = hex_decode(b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            crc_reg    <= 16'h0000;
            text_reg   <= 16'h0000;
            excess_reg <= 1'b0;
            line_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            text_reg   <= text_next;
            excess_reg <= excess_next;
            line_reg   <= line_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        text_next   = text_reg;
        excess_next = excess_reg;
        line_next   = line_reg;
        q_push      = 1'b0;
        q_data      = '{kind: K_HDR_CHAR, data: b, crc_calc: crc_reg, crc_text: text_reg};

        case (phase_reg)
            PH_HEADER: begin
                crc_next = crc16_byte(crc_reg, b);
                if (b == CH_LF) begin
                    phase_next  = PH_EMPTY;
                    line_next   = 1'b0;
                    q_push      = accept;
                    q_data.kind = K_HDR_END;
                end else if (b != CH_CR) begin
                    q_push      = accept;
                    q_data.kind = K_HDR_CHAR;
                end
            end
            PH_EMPTY: begin
                crc_next = crc16_byte(crc_reg, b);
                if (b == CH_LF) begin
                    line_next = 1'b0;
                    if (line_reg) begin
                        phase_next  = PH_IDLE;
                        q_push      = accept;
                        q_data.kind = K_ABANDON;
                    end else begin
                        phase_next = PH_LINES;
                    end
                end else if (b != CH_CR) begin
                    line_next = 1'b1;
                end
            end
            PH_LINES: begin
                crc_next = crc16_byte(crc_reg, b);
                if (!line_reg && b == CH_BANG) begin
                    text_next   = 16'h0000;
                    excess_next = 1'b0;
                    phase_next  = PH_CRC;
                end else if (b == CH_LF) begin
                    line_next   = 1'b0;
                    q_push      = accept;
                    q_data.kind = K_LN_END;
                end else if (b != CH_CR) begin
                    line_next   = 1'b1;
                    q_push      = accept;
                    q_data.kind = K_LN_CHAR;
                end
            end
            PH_CRC: begin
                if (b == CH_LF) begin
                    phase_next  = PH_IDLE;
                    line_next   = 1'b0;
                    q_push      = accept;
                    q_data.kind = (!excess_reg && text_reg == crc_reg) ? K_OK : K_CRC_ERR;
                end else if (b != CH_CR) begin
                    if (!hex[4]) begin
                        phase_next  = PH_IDLE;
                        line_next   = 1'b0;
                        q_push      = accept;
                        q_data.kind = K_ABANDON;
                    end else begin
                        // a nonzero nibble pushed off the top can never match
                        excess_next = excess_reg || (text_reg[15:12] != 4'h0);
                        text_next   = {text_reg[11:0], hex[3:0]};
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (b == CH_SLASH) begin
                    crc_next   = crc16_byte(16'h0000, b);
                    line_next  = 1'b0;
                    phase_next = PH_HEADER;
                end
            end
        endcase
    end

endmodule

// ----- hw/rtl/p1tp_fifo.sv -----
// Small register queue between the front end and the output stage.
`timescale 1ns / 1ps

module p1tp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  p1tp_pkg::event_t               push_data,
    input  logic                           pop,
    output p1tp_pkg::event_t               pop_data,
    output logic                           full,
    output logic                           empty,
    output logic [$clog2(DEPTH + 1) - 1:0] level
);
    import p1tp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    event_t             mem_reg [DEPTH];
    logic [PTR_W - 1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W - 1:0] count_reg,  count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == LVL_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign level    = count_reg;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + LVL_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/p1tp_back.sv -----
// Output stage: formats queued events into the result register.
`timescale 1ns / 1ps

module p1tp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  p1tp_pkg::event_t q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_out_kind,
    output logic [7:0]       m_out_byte,
    output logic [15:0]      m_crc_computed,
    output logic [15:0]      m_crc_received
);
    import p1tp_pkg::*;

    logic        valid_reg;
    logic [2:0]  kind_reg,  kind_next;
    logic [7:0]  byte_reg,  byte_next;
    logic [15:0] calc_reg,  calc_next;
    logic [15:0] text_reg,  text_next;
    logic        load;

    assign load  = !q_empty && (!valid_reg || m_ready);
    assign q_pop = load;

    // only character words carry a byte, only OK and CRC-error words carry CRCs
    always_comb begin
        kind_next = q_data.kind;
        byte_next = 8'h00;
        calc_next = 16'h0000;
        text_next = 16'h0000;
        case (q_data.kind)
            K_HDR_CHAR, K_LN_CHAR: begin
                byte_next = q_data.data;
            end
            K_OK, K_CRC_ERR: begin
                calc_next = q_data.crc_calc;
                text_next = q_data.crc_text;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            calc_reg <= calc_next;
            text_reg <= text_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_out_kind     = kind_reg;
    assign m_out_byte     = byte_reg;
    assign m_crc_computed = calc_reg;
    assign m_crc_received = text_reg;

endmodule

// ----- hw/rtl/p1_telegram_parser.sv -----
// Top level of the streaming P1 telegram parser with CRC-16/ARC check.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_in_byte
//  m_      | out       | m_valid / m_ready  | m_out_kind, m_out_byte, m_crc_computed,
//          |           |                    | m_crc_received
//
// One byte is taken per cycle while s_ready is high; the byte CRC update and phase logic are combinational.
// A result word passes through the event queue and the output register on its way to m_.
// s_ready drops only while the FIFO_DEPTH-entry event queue is full.
// Reset (aresetn low, synchronous) returns the parser to idle and empties queue and output.
`timescale 1ns / 1ps
`include "p1_telegram_parser_assert.svh"

module p1_telegram_parser #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_crc_computed,
    output logic [15:0] m_crc_received
);
    import p1tp_pkg::*;

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    event_t             push_data, pop_data;
    logic               push, pop, q_full, q_empty;
    logic [LVL_W - 1:0] q_level;

    p1tp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .q_push    (push),
        .q_data    (push_data)
    );

    p1tp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty),
        .level     (q_level)
    );

    p1tp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_data         (pop_data),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_byte     (m_out_byte),
        .m_crc_computed (m_crc_computed),
        .m_crc_received (m_crc_received)
    );

    `P1TP_ASSERT_SAME(a_level_bound, aclk, aresetn, 1'b1, q_level <= LVL_W'(FIFO_DEPTH), "event queue overflow")
    `P1TP_ASSERT_SAME(a_byte_zero, aclk, aresetn, m_valid && m_out_kind != K_HDR_CHAR && m_out_kind != K_LN_CHAR, m_out_byte == 8'h00, "byte set on non-character word")
    `P1TP_ASSERT_SAME(a_ok_match, aclk, aresetn, m_valid && m_out_kind == K_OK, m_crc_computed == m_crc_received, "ok word with CRC mismatch")
    `P1TP_ASSERT_NEXT(a_full_push, aclk, aresetn, q_full && !pop, q_full, "queue left full state without a pop")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the P1 telegram parser: telegram stimulus, live prediction, compare.
`timescale 1ns / 1ps

module testbench;
    import p1tp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_LEN      = 300;
    localparam int TAIL_CYCLES   = 20;
    localparam int PHASE_BYTES   = 340;

    typedef enum int {
        TG_GOOD,
        TG_LOWER,
        TG_LEAD_ZERO,
        TG_BAD_CRC,
        TG_EXCESS,
        TG_SHORT,
        TG_NO_DIGITS,
        TG_BAD_HEX,
        TG_NOT_EMPTY,
        TG_NOISE
    } tg_kind_t;

    typedef struct {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] crc_calc;
        logic [15:0] crc_text;
    } result_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [2:0]  m_out_kind;
    logic [7:0]  m_out_byte;
    logic [15:0] m_crc_computed;
    logic [15:0] m_crc_received;

    p1_telegram_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_byte     (m_out_byte),
        .m_crc_computed (m_crc_computed),
        .m_crc_received (m_crc_received)
    );

    // stimulus and expectations
    logic [7:0]   byte_q[$];
    result_word_t pending_words[$];
    logic [15:0]  gen_crc      = 16'h0000;
    int           items_made   = 0;
    int           telegrams    = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           hold_req     = 1'b0;
    int           hold_cnt     = 0;
    logic         holding;
    int           errors       = 0;
    int           cycle_cnt    = 0;
    int           words_seen   = 0;
    int           kind_seen[8];
    result_word_t head_word;

    // parser shadow state
    phase_t      ph_m       = PH_IDLE;
    logic [15:0] crc_acc    = 16'h0000;
    logic [15:0] crc_txt    = 16'h0000;
    bit          excess_m   = 1'b0;
    bit          line_busy  = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) begin
            r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
        end
        return r;
    endfunction

    // -1 when b is not an ASCII hex digit
    function automatic int nibble_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
        return -1;
    endfunction

    task automatic queue_word(input kind_t k, input logic [7:0] d,
                              input logic [15:0] cc, input logic [15:0] cr);
        result_word_t w;
        w.kind     = k;
        w.data     = d;
        w.crc_calc = cc;
        w.crc_text = cr;
        pending_words.push_back(w);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int nib;
        if (ph_m == PH_HEADER || ph_m == PH_EMPTY || ph_m == PH_LINES) begin
            crc_acc = crc_step(crc_acc, b);
        end
        case (ph_m)
            PH_HEADER: begin
                if (b == CH_LF) begin
                    ph_m      = PH_EMPTY;
                    line_busy = 1'b0;
                    queue_word(K_HDR_END, 8'h00, 16'h0, 16'h0);
                end else if (b != CH_CR) begin
                    queue_word(K_HDR_CHAR, b, 16'h0, 16'h0);
                end
            end
            PH_EMPTY: begin
                if (b == CH_LF) begin
                    if (line_busy) begin
                        ph_m = PH_IDLE;
                        queue_word(K_ABANDON, 8'h00, 16'h0, 16'h0);
                    end else begin
                        ph_m = PH_LINES;
                    end
                    line_busy = 1'b0;
                end else if (b != CH_CR) begin
                    line_busy = 1'b1;
                end
            end
            PH_LINES: begin
                if (!line_busy && b == CH_BANG) begin
                    crc_txt  = 16'h0000;
                    excess_m = 1'b0;
                    ph_m     = PH_CRC;
                end else if (b == CH_LF) begin
                    line_busy = 1'b0;
                    queue_word(K_LN_END, 8'h00, 16'h0, 16'h0);
                end else if (b != CH_CR) begin
                    line_busy = 1'b1;
                    queue_word(K_LN_CHAR, b, 16'h0, 16'h0);
                end
            end
            PH_CRC: begin
                if (b == CH_LF) begin
                    queue_word((!excess_m && crc_txt == crc_acc) ? K_OK : K_CRC_ERR,
                               8'h00, crc_acc, crc_txt);
                    ph_m      = PH_IDLE;
                    line_busy = 1'b0;
                end else if (b != CH_CR) begin
                    nib = nibble_of(b);
                    if (nib < 0) begin
                        ph_m      = PH_IDLE;
                        line_busy = 1'b0;
                        queue_word(K_ABANDON, 8'h00, 16'h0, 16'h0);
                    end else begin
                        if (crc_txt[15:12] != 4'h0) excess_m = 1'b1;
                        crc_txt = {crc_txt[11:0], 4'(nib)};
                    end
                end
            end
            default: begin
                ph_m = PH_IDLE;
                if (b == CH_SLASH) begin
                    crc_acc   = crc_step(16'h0000, b);
                    line_busy = 1'b0;
                    ph_m      = PH_HEADER;
                end
            end
        endcase
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic put_byte(input logic [7:0] b);
        byte_q.push_back(b);
        gen_crc = crc_step(gen_crc, b);
        items_made++;
    endtask

    task automatic put_eol();
        if ($urandom_range(3) != 0) put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    // any byte but LF; a line may not open with a bang
    function automatic logic [7:0] rand_char(input bit first_of_line);
        logic [7:0] c;
        do begin
            case ($urandom_range(9))
                0:       c = 8'($urandom_range(255));
                1:       c = first_of_line ? 8'($urandom_range(32, 126)) : CH_BANG;
                2:       c = CH_SLASH;
                default: c = 8'($urandom_range(32, 126));
            endcase
        end while (c == CH_LF || (first_of_line && c == CH_BANG));
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // low ndig nibbles of v, most significant first
    task automatic put_hex(input logic [15:0] v, input int ndig, input bit lower);
        for (int i = ndig - 1; i >= 0; i--) begin
            put_byte(hex_char(v[4*i +: 4], lower));
        end
    endtask

    task automatic send_telegram(input tg_kind_t k);
        logic [15:0] sent;
        logic [7:0]  c;
        int          n_lines;
        int          len;
        bit          lc;
        lc = $urandom_range(1);
        telegrams++;
        if (k == TG_NOISE) begin
            repeat ($urandom_range(3, 12)) put_byte(8'($urandom_range(255)));
            return;
        end
        gen_crc = 16'h0000;
        put_byte(CH_SLASH);
        repeat ($urandom_range(0, 6)) put_byte(rand_char(1'b0));
        put_eol();
        if (k == TG_NOT_EMPTY) begin
            repeat ($urandom_range(1, 4)) put_byte(rand_char(1'b0));
            put_eol();
            return;
        end
        put_eol();
        n_lines = $urandom_range(0, 4);
        for (int l = 0; l < n_lines; l++) begin
            len = $urandom_range(0, 8);
            for (int j = 0; j < len; j++) put_byte(rand_char(j == 0));
            put_eol();
        end
        put_byte(CH_BANG);
        sent = gen_crc;
        case (k)
            TG_LOWER:     put_hex(sent, 4, 1'b1);
            TG_LEAD_ZERO: begin
                repeat ($urandom_range(1, 3)) put_byte(8'h30);
                put_hex(sent, 4, lc);
            end
            TG_BAD_CRC:   put_hex(sent ^ 16'($urandom_range(1, 65535)), 4, lc);
            TG_EXCESS: begin
                put_byte(hex_char(4'($urandom_range(1, 15)), lc));
                put_hex(sent, 4, lc);
            end
            TG_SHORT:     put_hex(sent, $urandom_range(1, 3), lc);
            TG_NO_DIGITS: ;
            TG_BAD_HEX: begin
                put_hex(sent, $urandom_range(0, 3), lc);
                do begin
                    c = 8'($urandom_range(255));
                end while (nibble_of(c) >= 0 || c == CH_CR || c == CH_LF);
                put_byte(c);
            end
            default:      put_hex(sent, 4, lc);
        endcase
        put_eol();
    endtask

    function automatic tg_kind_t pick_variant();
        int r;
        r = $urandom_range(99);
        if (r < 40) return TG_GOOD;
        if (r < 50) return TG_LOWER;
        if (r < 58) return TG_LEAD_ZERO;
        if (r < 66) return TG_BAD_CRC;
        if (r < 72) return TG_EXCESS;
        if (r < 78) return TG_SHORT;
        if (r < 84) return TG_NO_DIGITS;
        if (r < 90) return TG_BAD_HEX;
        if (r < 95) return TG_NOT_EMPTY;
        return TG_NOISE;
    endfunction

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_in_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) parse_byte(s_in_byte);
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= byte_q.pop_front();
                end else begin
                    s_valid   <= 1'b0;
                end
            end
        end
    end

    // ---------------- long receiver hold-off ----------------

    // one long hold-off so the event queue fills and s_ready drops
    assign holding = hold_req && (hold_cnt < HOLD_LEN);

    always @(posedge aclk) begin
        if (holding) hold_cnt <= hold_cnt + 1;
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                kind_seen[m_out_kind]++;
                if (pending_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word: kind %0d byte %02h crc %04h/%04h",
                             $time, m_out_kind, m_out_byte, m_crc_computed, m_crc_received);
                end else begin
                    head_word = pending_words.pop_front();
                    if (m_out_kind !== head_word.kind || m_out_byte !== head_word.data ||
                        m_crc_computed !== head_word.crc_calc ||
                        m_crc_received !== head_word.crc_text) begin
                        errors++;
                        $display({"%0t: expected kind %0d byte %02h crc %04h/%04h,",
                                  " got %0d %02h %04h/%04h"},
                                 $time, head_word.kind, head_word.data, head_word.crc_calc,
                                 head_word.crc_text, m_out_kind, m_out_byte, m_crc_computed,
                                 m_crc_received);
                    end
                end
            end
            if (holding) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("p1_telegram_parser: mismatch");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int send_tab[4];
        int recv_tab[4];
        logic [15:0] sent;
        send_tab = '{0, 62, 0, 38};
        recv_tab = '{0, 0, 62, 38};
        foreach (kind_seen[i]) kind_seen[i] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_tab[p];
            recv_stall_pct = recv_tab[p];
            if (p == 2) hold_req = 1'b1;
            if (p == 0) begin
                // idle noise, then one telegram with edge bytes, slashes and an inner bang
                put_byte(8'h00);
                put_byte(8'hFF);
                put_byte(CH_LF);
                gen_crc = 16'h0000;
                put_byte(CH_SLASH);
                put_byte(8'hFF);
                put_byte(CH_SLASH);
                put_byte(CH_CR);
                put_byte(CH_LF);
                put_byte(CH_LF);
                put_byte(8'h61);
                put_byte(CH_BANG);
                put_byte(8'h80);
                put_byte(CH_LF);
                put_byte(CH_LF);
                put_byte(CH_BANG);
                sent = gen_crc;
                put_hex(sent, 4, 1'b0);
                put_byte(CH_CR);
                put_byte(CH_LF);
                telegrams++;
                for (int v = TG_GOOD; v <= TG_NOISE; v++) send_telegram(tg_kind_t'(v));
            end
            while (items_made < (p + 1) * PHASE_BYTES) send_telegram(pick_variant());
            // sender waits until every result of the phase is back
            while (byte_q.size() != 0 || s_valid || pending_words.size() != 0) begin
                @(negedge aclk);
            end
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_words.size() != 0) begin
            errors++;
            $display("%0t: %0d expected words never arrived, next kind %0d",
                     $time, pending_words.size(), pending_words[0].kind);
        end
        $display("sent %0d bytes in %0d telegrams/noise bursts over four idling phases",
                 items_made, telegrams);
        $display("checked %0d words: %0d ok, %0d crc error, %0d abandoned, %0d errors",
                 words_seen, kind_seen[K_OK], kind_seen[K_CRC_ERR], kind_seen[K_ABANDON],
                 errors);
        if (errors == 0) begin
            $display("p1_telegram_parser: match");
        end else begin
            $display("p1_telegram_parser: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/p1tp_pkg.sv
hw/rtl/p1tp_front.sv
hw/rtl/p1tp_fifo.sv
hw/rtl/p1tp_back.sv
hw/rtl/p1_telegram_parser.sv
tb/sv/testbench.sv
